@@ rtl/core/sha256_byte_stream_hasher_unit_macros.svh @@
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher - assertion macros
// Implication checks on the rising edge of clk, off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SHA256_BYTE_STREAM_HASHER_UNIT_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define SHBH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SHBH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SHBH_ASSERT_IMP(lbl, ante, cons, msg)
`define SHBH_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/core/shbh_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher - package
// Round constants, initial hash value, control types and SHA-256 functions.
// ----------------------------------------------------------------------------
package shbh_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned NumWords = 8;
  localparam int unsigned SchedW   = 16;

  localparam logic [5:0] LastRound = 6'd63;
  localparam logic [5:0] LastByte  = 6'd63;
  localparam logic [5:0] PadFill   = 6'd56;
  localparam logic [7:0] PadMarker = 8'h80;
  localparam logic [2:0] LastLen   = 3'd7;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ROUND = 5'b00010,
    ST_FOLD  = 5'b00100,
    ST_PAD   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  typedef enum logic [2:0] {
    PS_MARK = 3'b001,
    PS_ZERO = 3'b010,
    PS_LEN  = 3'b100
  } pad_step_t;

  typedef struct packed {
    logic init;
    logic load;
    logic step;
    logic fold;
  } rnd_ctl_t;

  typedef struct packed {
    logic       put;
    logic [7:0] data;
    logic       step;
  } sch_ctl_t;

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  function automatic logic [31:0] ch_f(input logic [31:0] e, input logic [31:0] f,
                                       input logic [31:0] g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] maj_f(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

@@ rtl/core/shbh_sched.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher - block buffer and message schedule
// Sixteen-word window: bytes shift in while a block fills, then words
// shift out one per round with the expanded word shifted in behind.
// ----------------------------------------------------------------------------
module shbh_sched (
  input  logic             clk,
  input  shbh_pkg::sch_ctl_t ctl,
  output logic [31:0]      w
);

  logic [31:0] win_r [shbh_pkg::SchedW];
  logic [31:0] w_new;

  assign w_new = shbh_pkg::ssig1(win_r[14]) + win_r[9]
               + shbh_pkg::ssig0(win_r[1]) + win_r[0];
  assign w = win_r[0];

  always_ff @(posedge clk) begin
    if (ctl.put) begin
      for (int i = 0; i < shbh_pkg::SchedW - 1; i++) begin
        win_r[i] <= {win_r[i][23:0], win_r[i+1][31:24]};
      end
      win_r[shbh_pkg::SchedW-1] <= {win_r[shbh_pkg::SchedW-1][23:0], ctl.data};
    end else if (ctl.step) begin
      for (int i = 0; i < shbh_pkg::SchedW - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[shbh_pkg::SchedW-1] <= w_new;
    end
  end

endmodule

@@ rtl/core/shbh_round.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher - round unit
// Working variables a..h updated one round per cycle while ctl.step is high;
// chaining words folded in after the last round and reset to the initial value.
// ----------------------------------------------------------------------------
module shbh_round (
  input  logic               clk,
  input  logic               rst_n,
  input  shbh_pkg::rnd_ctl_t ctl,
  input  logic [31:0]        w,
  input  logic [31:0]        k,
  output logic [255:0]       digest
);

  logic [31:0] wv_r    [shbh_pkg::NumWords];
  logic [31:0] chain_r [shbh_pkg::NumWords];
  logic [31:0] t1;
  logic [31:0] t2;

  assign t1 = wv_r[7] + shbh_pkg::bsig1(wv_r[4])
            + shbh_pkg::ch_f(wv_r[4], wv_r[5], wv_r[6]) + k + w;
  assign t2 = shbh_pkg::bsig0(wv_r[0]) + shbh_pkg::maj_f(wv_r[0], wv_r[1], wv_r[2]);

  always_comb begin
    for (int i = 0; i < shbh_pkg::NumWords; i++) begin
      digest[255 - 32*i -: 32] = chain_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      for (int i = 0; i < shbh_pkg::NumWords; i++) begin
        wv_r[i] <= chain_r[i];
      end
    end else if (ctl.step) begin
      wv_r[7] <= wv_r[6];
      wv_r[6] <= wv_r[5];
      wv_r[5] <= wv_r[4];
      wv_r[4] <= wv_r[3] + t1;
      wv_r[3] <= wv_r[2];
      wv_r[2] <= wv_r[1];
      wv_r[1] <= wv_r[0];
      wv_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.init) begin
      for (int i = 0; i < shbh_pkg::NumWords; i++) begin
        chain_r[i] <= shbh_pkg::InitHash[i];
      end
    end else if (ctl.fold) begin
      for (int i = 0; i < shbh_pkg::NumWords; i++) begin
        chain_r[i] <= chain_r[i] + wv_r[i];
      end
    end
  end

endmodule

@@ rtl/core/sha256_byte_stream_hasher_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Hashes a message fed one byte per item and returns the 256-bit digest.
// ----------------------------------------------------------------------------
// Input channel in_*: one message byte per item, in_is_last on the final
// item, in_no_byte set when the item carries no byte (empty message end).
// Output channel out_*: one item per message, the digest as four 64-bit
// words, h0/h1 in out_digest_part0 through h6/h7 in out_digest_part3.
// A byte that does not complete a block is taken while idle. The byte
// that completes a block starts 64 rounds of the single round unit, one
// per cycle, then a fold into the chaining words. A last item adds the
// padding bytes (9 to 72 bytes), one or two more compressions and the
// load of the output register.
// in_stall is high throughout; the next message may start while the digest
// item still waits on out_stall, but a second digest holds until the first
// is taken.
// Reset (synchronous, rst_n low) restores the initial hash value, empties
// the block buffer and drops any pending output item.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_is_last,
  input  logic        in_no_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_digest_part0,
  output logic [63:0] out_digest_part1,
  output logic [63:0] out_digest_part2,
  output logic [63:0] out_digest_part3
);

  `include "sha256_byte_stream_hasher_unit_macros.svh"

  shbh_pkg::state_t    state_r,   state_nxt;
  shbh_pkg::pad_step_t step_r,    step_nxt;
  logic [5:0]          fill_r,    fill_nxt;
  logic [60:0]         total_r,   total_nxt;
  logic [5:0]          rnd_r,     rnd_nxt;
  logic [2:0]          len_r,     len_nxt;
  logic                pad_act_r, pad_act_nxt;
  logic                fin_r,     fin_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [255:0]        digest_r;

  shbh_pkg::rnd_ctl_t  rnd_ctl;
  shbh_pkg::sch_ctl_t  sch_ctl;
  logic [31:0]         w;
  logic [255:0]        digest;
  logic                in_acc;
  logic                load_out;
  logic [5:0]          fill_inc;
  logic [63:0]         len_bits;

  assign in_stall = (state_r != shbh_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign fill_inc = fill_r + 6'd1;
  assign len_bits = {total_r, 3'b000} << {len_r, 3'b000};

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    fill_nxt      = fill_r;
    total_nxt     = total_r;
    rnd_nxt       = rnd_r;
    len_nxt       = len_r;
    pad_act_nxt   = pad_act_r;
    fin_nxt       = fin_r;
    out_valid_nxt = out_valid_r && out_stall;
    load_out      = 1'b0;
    rnd_ctl       = '0;
    sch_ctl       = '0;

    case (state_r)
      shbh_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (!in_no_byte) begin
            sch_ctl.put  = 1'b1;
            sch_ctl.data = in_data_byte;
            total_nxt    = total_r + 61'd1;
          end
          if (in_is_last) begin
            pad_act_nxt = 1'b1;
            step_nxt    = shbh_pkg::PS_MARK;
            len_nxt     = '0;
            state_nxt   = shbh_pkg::ST_PAD;
          end
        end
      end
      shbh_pkg::ST_ROUND: begin
        sch_ctl.step = 1'b1;
        rnd_ctl.step = 1'b1;
        rnd_nxt      = rnd_r + 6'd1;
        if (rnd_r == shbh_pkg::LastRound) begin
          state_nxt = shbh_pkg::ST_FOLD;
        end
      end
      shbh_pkg::ST_FOLD: begin
        rnd_ctl.fold = 1'b1;
        if (fin_r) begin
          state_nxt = shbh_pkg::ST_DONE;
        end else if (pad_act_r) begin
          state_nxt = shbh_pkg::ST_PAD;
        end else begin
          state_nxt = shbh_pkg::ST_IDLE;
        end
      end
      shbh_pkg::ST_PAD: begin
        sch_ctl.put = 1'b1;
        case (step_r)
          shbh_pkg::PS_MARK, shbh_pkg::PS_ZERO: begin
            sch_ctl.data = (step_r == shbh_pkg::PS_MARK) ? shbh_pkg::PadMarker : 8'h00;
            step_nxt     = (fill_inc == shbh_pkg::PadFill) ? shbh_pkg::PS_LEN
                                                           : shbh_pkg::PS_ZERO;
          end
          shbh_pkg::PS_LEN: begin
            sch_ctl.data = len_bits[63:56];
            len_nxt      = len_r + 3'd1;
            if (len_r == shbh_pkg::LastLen) begin
              fin_nxt = 1'b1;
            end
          end
          default: begin
            step_nxt = shbh_pkg::PS_MARK;
          end
        endcase
      end
      shbh_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          rnd_ctl.init  = 1'b1;
          total_nxt     = '0;
          pad_act_nxt   = 1'b0;
          fin_nxt       = 1'b0;
          state_nxt     = shbh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = shbh_pkg::ST_IDLE;
      end
    endcase

    if (sch_ctl.put) begin
      fill_nxt = fill_inc;
      if (fill_r == shbh_pkg::LastByte) begin
        rnd_ctl.load = 1'b1;
        rnd_nxt      = '0;
        state_nxt    = shbh_pkg::ST_ROUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= shbh_pkg::ST_IDLE;
      step_r      <= shbh_pkg::PS_MARK;
      fill_r      <= '0;
      total_r     <= '0;
      rnd_r       <= '0;
      len_r       <= '0;
      pad_act_r   <= 1'b0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      fill_r      <= fill_nxt;
      total_r     <= total_nxt;
      rnd_r       <= rnd_nxt;
      len_r       <= len_nxt;
      pad_act_r   <= pad_act_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      digest_r <= digest;
    end
  end

  shbh_sched u_sched (
    .clk (clk),
    .ctl (sch_ctl),
    .w   (w)
  );

  shbh_round u_round (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (rnd_ctl),
    .w      (w),
    .k      (shbh_pkg::RoundK[rnd_r]),
    .digest (digest)
  );

  assign out_valid        = out_valid_r;
  assign out_digest_part0 = digest_r[255:192];
  assign out_digest_part1 = digest_r[191:128];
  assign out_digest_part2 = digest_r[127:64];
  assign out_digest_part3 = digest_r[63:0];

  `SHBH_ASSERT_NXT(a_round_end, (state_r == shbh_pkg::ST_ROUND) && (rnd_r == shbh_pkg::LastRound), state_r == shbh_pkg::ST_FOLD, "last round not followed by fold")
  `SHBH_ASSERT_IMP(a_done_empty, state_r == shbh_pkg::ST_DONE, (fill_r == '0) && fin_r, "digest pending with partial block")
  `SHBH_ASSERT_NXT(a_out_load, (state_r == shbh_pkg::ST_DONE) && !(out_valid_r && out_stall), out_valid_r && (state_r == shbh_pkg::ST_IDLE), "digest not presented")
  `SHBH_ASSERT_IMP(a_pad_flag, state_r == shbh_pkg::ST_PAD, pad_act_r && !fin_r, "padding without an open message end")

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher - testbench
// Feeds messages byte by byte, with empty messages, no-byte items and lengths
// around the padding boundaries. A built-in SHA-256 model predicts each
// digest, and the digests that come out are checked field by field. Traffic
// runs in phases of free flow, sender gaps, receiver stalls and both, with
// one long receiver hold that backs the block up.
// ----------------------------------------------------------------------------
module tb;

  localparam int HOLD_CYCLES = 600;
  localparam int PHASE_ITEMS = 250;
  localparam int PHASE_MSGS  = 4;

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef enum int {
    RUN_FREE,
    RUN_SRC_IDLE,
    RUN_SINK_STALL,
    RUN_BOTH
  } traffic_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       no_byte;
  } byte_item_t;

  typedef logic [3:0][63:0] digest_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_is_last = 1'b0;
  logic        in_no_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_digest_part0;
  logic [63:0] out_digest_part1;
  logic [63:0] out_digest_part2;
  logic [63:0] out_digest_part3;

  byte_item_t byte_feed_q[$];
  digest_t    pending_digests[$];
  traffic_t   traffic = RUN_FREE;
  logic       in_taken = 1'b0;
  int         mismatches = 0;
  int         queued_items = 0;
  int         hold_seq = 0;
  int         hold_seen = 0;
  int         hold_left = 0;

  // model state
  logic [31:0] chain_w [8];
  logic [7:0]  blk_buf [64];
  logic [5:0]  blk_fill;
  logic [60:0] msg_bytes;

  sha256_byte_stream_hasher_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_is_last       (in_is_last),
    .in_no_byte       (in_no_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_digest_part0 (out_digest_part0),
    .out_digest_part1 (out_digest_part1),
    .out_digest_part2 (out_digest_part2),
    .out_digest_part3 (out_digest_part3)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress_block();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] wk, s0, s1, t1, t2;
    for (int k = 0; k < 16; k++)
      w[k] = {blk_buf[4*k], blk_buf[4*k+1], blk_buf[4*k+2], blk_buf[4*k+3]};
    for (int k = 0; k < 8; k++)
      v[k] = chain_w[k];
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        wk = w[r];
      end else begin
        s0 = rotr(w[(r-15)&15], 7) ^ rotr(w[(r-15)&15], 18) ^ (w[(r-15)&15] >> 3);
        s1 = rotr(w[(r-2)&15], 17) ^ rotr(w[(r-2)&15], 19) ^ (w[(r-2)&15] >> 10);
        wk = w[r&15] + s0 + w[(r-7)&15] + s1;
        w[r&15] = wk;
      end
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[r] + wk;
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int k = 0; k < 8; k++)
      chain_w[k] = chain_w[k] + v[k];
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    blk_buf[blk_fill] = b;
    blk_fill = blk_fill + 6'd1;
    if (blk_fill == 6'd0)
      compress_block();
  endfunction

  function automatic void restart_hash();
    for (int k = 0; k < 8; k++)
      chain_w[k] = SHA_IV[k];
    blk_fill = 6'd0;
    msg_bytes = '0;
  endfunction

  // returns 1 when the item closes a message; digest in d
  function automatic bit hash_absorb_item(input byte_item_t it, output digest_t d);
    logic [63:0] bit_len;
    d = '0;
    if (!it.no_byte) begin
      msg_bytes = msg_bytes + 61'd1;
      absorb_byte(it.data);
    end
    if (!it.last)
      return 1'b0;
    bit_len = {msg_bytes, 3'b000};
    absorb_byte(8'h80);
    while (blk_fill != 6'd56)
      absorb_byte(8'h00);
    for (int k = 0; k < 8; k++)
      absorb_byte(bit_len[63 - 8*k -: 8]);
    for (int k = 0; k < 4; k++)
      d[k] = {chain_w[2*k], chain_w[2*k+1]};
    restart_hash();
    return 1'b1;
  endfunction

  function automatic bit sender_rests();
    case (traffic)
      RUN_SRC_IDLE: return $urandom_range(0, 99) < 47;
      RUN_BOTH:     return $urandom_range(0, 99) < 8;
      default:      return 1'b0;
    endcase
  endfunction

  function automatic bit sink_rests();
    case (traffic)
      RUN_SINK_STALL: return $urandom_range(0, 99) < 47;
      RUN_BOTH:       return $urandom_range(0, 99) < 8;
      default:        return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] exp_v,
                                 input logic [63:0] act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %h, got %h", what, exp_v, act_v);
  endtask

  // sender
  always @(negedge clk) begin : drive_in
    byte_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // stalled: hold the item
    end else if (byte_feed_q.size() != 0 && !sender_rests()) begin
      it = byte_feed_q.pop_front();
      in_valid     <= 1'b1;
      in_data_byte <= it.data;
      in_is_last   <= it.last;
      in_no_byte   <= it.no_byte;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_seq) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= sink_rests();
    end
  end

  always @(posedge clk) begin : watch
    digest_t got, want;
    byte_item_t it;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = {out_digest_part3, out_digest_part2, out_digest_part1, out_digest_part0};
        if (pending_digests.size() == 0) begin
          report_mismatch("unexpected digest, part0", 64'd0, got[0]);
        end else begin
          want = pending_digests.pop_front();
          for (int k = 0; k < 4; k++)
            if (got[k] !== want[k])
              report_mismatch($sformatf("digest_part%0d", k), want[k], got[k]);
        end
      end
      if (in_valid && !in_stall) begin
        it = byte_item_t'{data: in_data_byte, last: in_is_last, no_byte: in_no_byte};
        if (hash_absorb_item(it, want))
          pending_digests.push_back(want);
      end
    end
  end

  task automatic push_item(input logic [7:0] data, input logic last, input logic nb);
    byte_feed_q.push_back(byte_item_t'{data: data, last: last, no_byte: nb});
    if (!nb || last)
      queued_items++;
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(0, 16);
    if (r < 80) return $urandom_range(52, 72);
    if (r < 92) return $urandom_range(116, 132);
    return $urandom_range(0, 140);
  endfunction

  task automatic push_message(input int len);
    int  fill_mode;
    bit  end_empty;
    logic [7:0] b;
    fill_mode = $urandom_range(0, 9);
    end_empty = (len == 0) || ($urandom_range(0, 9) == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 31) == 0)
        push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      case (fill_mode)
        0:       b = 8'h00;
        1:       b = 8'hff;
        default: b = 8'($urandom_range(0, 255));
      endcase
      push_item(b, (i == len - 1) && !end_empty, 1'b0);
    end
    if (end_empty)
      push_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
  endtask

  task automatic wait_drained();
    while (byte_feed_q.size() != 0 || in_valid || pending_digests.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    int start_items, msgs;
    restart_hash();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty message, ignored data
    push_item(8'hff, 1'b1, 1'b1);
    // no-byte filler then empty end
    push_item(8'hff, 1'b0, 1'b1);
    push_item(8'h00, 1'b1, 1'b1);
    push_item(8'h00, 1'b1, 1'b0);
    push_item(8'hff, 1'b1, 1'b0);
    push_item(8'h61, 1'b0, 1'b0);
    push_item(8'h62, 1'b0, 1'b0);
    push_item(8'h63, 1'b1, 1'b0);
    // filler mid-message, end carried by a no-byte item
    push_item(8'hff, 1'b0, 1'b0);
    push_item(8'h5a, 1'b0, 1'b1);
    push_item(8'h00, 1'b0, 1'b0);
    push_item(8'ha5, 1'b1, 1'b1);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      traffic = traffic_t'(ph);
      // long sink hold while the sender keeps going
      if (traffic == RUN_FREE)
        hold_seq++;
      start_items = queued_items;
      msgs = 0;
      while (queued_items - start_items < PHASE_ITEMS || msgs < PHASE_MSGS) begin
        push_message(pick_len());
        msgs++;
      end
      wait_drained();
    end

    traffic = RUN_FREE;
    repeat (300) @(posedge clk);
    if (mismatches == 0 && pending_digests.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/shbh_pkg.sv
rtl/core/shbh_sched.sv
rtl/core/shbh_round.sv
rtl/core/sha256_byte_stream_hasher_unit.sv
tb/tb.sv
